// ===== sv/ppm_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// PPM frame decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_MACROS_SVH
`define PPM_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPMFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ppm frame decoder check failed");

// next-cycle implication, disabled during reset
`define PPMFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ppm frame decoder check failed");

`endif

// ===== sv/ppmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Widths, status and register codes, and shared types.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int CHAN_NUM_W   = 4;
	localparam int TIME_W       = 32;
	localparam int VAL_W        = 16;
	localparam int WIN_W        = VAL_W + 1;
	localparam int REG_IDX_W    = 2;

	// result status codes
	localparam logic [1:0] STAT_STORED  = 2'd0;
	localparam logic [1:0] STAT_FRAME   = 2'd1;
	localparam logic [1:0] STAT_DROP    = 2'd2;
	localparam logic [1:0] STAT_OVERRUN = 2'd3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_GAP = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TOL = 2'd3;

	localparam logic [TIME_W-1:0] GAP_RST = 32'd3000;
	localparam logic [VAL_W-1:0]  MIN_RST = 16'd1000;
	localparam logic [VAL_W-1:0]  MAX_RST = 16'd2000;
	localparam logic [VAL_W-1:0]  TOL_RST = 16'd100;

	typedef struct packed {
		logic [VAL_W-1:0] min_width;
		logic [VAL_W-1:0] max_width;
		logic [VAL_W-1:0] tolerance;
	} win_cfg_t;

	typedef struct packed {
		logic             in_range;
		logic [VAL_W-1:0] held;
	} win_res_t;

endpackage

// ===== sv/ppmfd_in_if.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder input channel
// Valid/ready channel carrying one edge timestamp per item.
// ----------------------------------------------------------------------------
interface ppmfd_in_if;
	logic                             valid;
	logic                             ready;
	logic [ppmfd_pkg::TIME_W-1:0]     capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink (input valid, input capture_time, output ready);
endinterface

// ===== sv/ppmfd_out_if.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder output channel
// Valid/ready channel carrying one decode result per item.
// ----------------------------------------------------------------------------
interface ppmfd_out_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       status;
	logic [ppmfd_pkg::CHAN_NUM_W-1:0] channel_number;
	logic [ppmfd_pkg::VAL_W-1:0]      channel_value;
	logic                             channel_in_range;
	logic                             frame_invalid;
	logic                             last_of_run;

	modport source (output valid, output status, output channel_number,
		output channel_value, output channel_in_range, output frame_invalid,
		output last_of_run, input ready);
	modport sink (input valid, input status, input channel_number,
		input channel_value, input channel_in_range, input frame_invalid,
		input last_of_run, output ready);
endinterface

// ===== sv/ppmfd_window.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder window check
// Shared compare unit: tests one width against the tolerance window and
// gives the saturated value to hold.
// ----------------------------------------------------------------------------
module ppmfd_window (
	input  ppmfd_pkg::win_cfg_t                cfg,
	input  logic [ppmfd_pkg::WIN_W-1:0]        width,
	output ppmfd_pkg::win_res_t                res
);

	logic [ppmfd_pkg::VAL_W-1:0] lo;
	logic [ppmfd_pkg::WIN_W-1:0] hi;

	always_comb begin
		// lower bound saturates at zero, upper bound kept in 17 bits
		lo = (cfg.min_width > cfg.tolerance) ? (cfg.min_width - cfg.tolerance) : '0;
		hi = {1'b0, cfg.max_width} + {1'b0, cfg.tolerance};
		res.in_range = (width >= {1'b0, lo}) && (width <= hi);
		res.held = width[ppmfd_pkg::VAL_W] ? '1 : width[ppmfd_pkg::VAL_W-1:0];
	end

endmodule

// ===== sv/ppm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder
// Turns edge timestamps into channel widths and held channel values.
// ----------------------------------------------------------------------------
// Each timestamp is captured in the idle state, and its interval is
// computed and classified in the calc state; a stored width, dropped frame
// or overrun then gives one result from the output register, and the next
// timestamp can be taken while that result waits. A sync gap that closes
// a full frame walks the CHANNELS stored widths through the single
// window-compare unit, one per cycle, then emits one result per cycle
// while the sink is ready, with the input held off throughout.
module ppm_frame_decoder #(
	parameter int CHANNELS = ppmfd_pkg::CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ppmfd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [ppmfd_pkg::TIME_W-1:0]         cfg_wdata,
	ppmfd_in_if.sink                             in_ch,
	ppmfd_out_if.source                          out_ch
);

	`include "ppm_frame_decoder_macros.svh"

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W = $clog2(CHANNELS + 1);
	localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
	localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(CHANNELS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                      state_q;
	logic [ppmfd_pkg::TIME_W-1:0]    gap_q;
	ppmfd_pkg::win_cfg_t             win_cfg_q;
	logic [ppmfd_pkg::TIME_W-1:0]    cap_q;
	logic [ppmfd_pkg::TIME_W-1:0]    prev_q;
	logic [SLOT_W-1:0]               slot_q;
	logic [CH_W-1:0]                 ch_q;
	logic [CHANNELS-1:0]             ok_q;
	logic                            inv_q;
	logic [ppmfd_pkg::VAL_W-1:0]     hold_q [CHANNELS];
	logic [ppmfd_pkg::WIN_W-1:0]     store_q [CHANNELS];

	logic                            out_valid_q;
	logic [1:0]                      out_status_q;
	logic [ppmfd_pkg::CHAN_NUM_W-1:0] out_chan_q;
	logic [ppmfd_pkg::VAL_W-1:0]     out_value_q;
	logic                            out_inr_q;
	logic                            out_inv_q;
	logic                            out_last_q;

	logic [ppmfd_pkg::TIME_W-1:0]    width;
	logic [ppmfd_pkg::WIN_W-1:0]     width_clip;
	logic                            is_gap;
	logic                            out_free;
	logic                            out_load;
	ppmfd_pkg::win_res_t             win_res;

	always_comb begin
		width      = cap_q - prev_q;
		width_clip = (|width[ppmfd_pkg::TIME_W-1:ppmfd_pkg::WIN_W]) ? '1
			: width[ppmfd_pkg::WIN_W-1:0];
		is_gap     = (width > gap_q) && (prev_q != '0);
		out_free   = !out_valid_q || out_ch.ready;
		// a new item enters the output register this cycle
		out_load   = out_free && ((state_q == ST_CALC && !(is_gap && slot_q == SLOT_FULL))
			|| state_q == ST_EMIT);
	end

	ppmfd_window u_window (
		.cfg   (win_cfg_q),
		.width (store_q[ch_q]),
		.res   (win_res)
	);

	assign in_ch.ready             = (state_q == ST_IDLE);
	assign out_ch.valid            = out_valid_q;
	assign out_ch.status           = out_status_q;
	assign out_ch.channel_number   = out_chan_q;
	assign out_ch.channel_value    = out_value_q;
	assign out_ch.channel_in_range = out_inr_q;
	assign out_ch.frame_invalid    = out_inv_q;
	assign out_ch.last_of_run      = out_last_q;

	// width store: only the CHANNELS slots read at frame end are kept
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && out_free && slot_q < SLOT_FULL) begin
			store_q[slot_q[CH_W-1:0]] <= width_clip;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			cap_q <= in_ch.capture_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			gap_q        <= ppmfd_pkg::GAP_RST;
			win_cfg_q    <= '{ppmfd_pkg::MIN_RST, ppmfd_pkg::MAX_RST, ppmfd_pkg::TOL_RST};
			prev_q       <= '0;
			slot_q       <= '0;
			ch_q         <= '0;
			ok_q         <= '0;
			inv_q        <= 1'b0;
			hold_q       <= '{default: '0};
			out_valid_q  <= 1'b0;
			out_status_q <= ppmfd_pkg::STAT_STORED;
			out_chan_q   <= '0;
			out_value_q  <= '0;
			out_inr_q    <= 1'b0;
			out_inv_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ppmfd_pkg::REG_GAP: gap_q <= cfg_wdata;
					ppmfd_pkg::REG_MIN: win_cfg_q.min_width <= cfg_wdata[ppmfd_pkg::VAL_W-1:0];
					ppmfd_pkg::REG_MAX: win_cfg_q.max_width <= cfg_wdata[ppmfd_pkg::VAL_W-1:0];
					ppmfd_pkg::REG_TOL: win_cfg_q.tolerance <= cfg_wdata[ppmfd_pkg::VAL_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (out_free) begin
						prev_q <= cap_q;
						if (is_gap && slot_q == SLOT_FULL) begin
							slot_q  <= '0;
							ch_q    <= '0;
							inv_q   <= 1'b0;
							state_q <= ST_CHECK;
						end else begin
							out_chan_q  <= '0;
							out_value_q <= '0;
							out_inr_q   <= 1'b0;
							out_inv_q   <= 1'b0;
							out_last_q  <= 1'b1;
							state_q     <= ST_IDLE;
							if (is_gap) begin
								slot_q       <= '0;
								out_status_q <= ppmfd_pkg::STAT_DROP;
							end else if (slot_q == SLOT_FULL) begin
								slot_q       <= '0;
								out_status_q <= ppmfd_pkg::STAT_OVERRUN;
							end else begin
								slot_q       <= slot_q + 1'b1;
								out_status_q <= ppmfd_pkg::STAT_STORED;
							end
						end
					end
				end
				ST_CHECK: begin
					ok_q[ch_q] <= win_res.in_range;
					if (win_res.in_range) begin
						hold_q[ch_q] <= win_res.held;
					end else begin
						inv_q <= 1'b1;
					end
					if (ch_q == CH_LAST) begin
						ch_q    <= '0;
						state_q <= ST_EMIT;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_status_q <= ppmfd_pkg::STAT_FRAME;
						out_chan_q   <= ppmfd_pkg::CHAN_NUM_W'(ch_q);
						out_value_q  <= hold_q[ch_q];
						out_inr_q    <= ok_q[ch_q];
						out_inv_q    <= inv_q;
						out_last_q   <= (ch_q == CH_LAST);
						if (ch_q == CH_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PPMFD_ASSERT_SAME(a_slot_bound, clk, arst_n, 1'b1, slot_q <= SLOT_FULL)
	`PPMFD_ASSERT_NEXT(a_accept_calc, clk, arst_n,
		in_ch.valid && in_ch.ready, state_q == ST_CALC)
	`PPMFD_ASSERT_SAME(a_frame_last, clk, arst_n,
		out_valid_q && out_status_q == ppmfd_pkg::STAT_FRAME && out_last_q,
		out_chan_q == ppmfd_pkg::CHAN_NUM_W'(CHANNELS - 1))
	`PPMFD_ASSERT_SAME(a_single_res, clk, arst_n,
		out_valid_q && out_status_q != ppmfd_pkg::STAT_FRAME,
		out_last_q && out_chan_q == '0 && !out_inr_q)

endmodule
